/* hw/rtl/nearest_neighbor_point_tracker_top_assert.svh */
// Assertion macros for the point tracker.
`ifndef NEAREST_NEIGHBOR_POINT_TRACKER_TOP_ASSERT_SVH
`define NEAREST_NEIGHBOR_POINT_TRACKER_TOP_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define NNPT_ASSERT_IMP(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("nnpt check failed");
// Next-cycle implication checked outside reset.
`define NNPT_ASSERT_NXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("nnpt check failed");
`endif

/* hw/rtl/nnpt_pkg.sv */
// Shared types and constants of the point tracker.
package nnpt_pkg;
  localparam int unsigned CoordW = 20;
  localparam int unsigned IdW = 16;
  localparam int unsigned DistW = 43;

  typedef enum logic [1:0] {
    EV_ENTER = 2'd0,
    EV_MOVE  = 2'd1,
    EV_LEAVE = 2'd2
  } ev_kind_e;

  typedef enum logic {
    CFG_TRACK_EN = 1'b0,
    CFG_MAX_DIST = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic signed [CoordW-1:0] z;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] x;
  } vec_t;

  typedef struct packed {
    logic [1:0]      kind;
    logic [IdW-1:0]  id;
    vec_t            cur;
    vec_t            prev;
    logic            last;
  } event_t;
endpackage

/* hw/rtl/nnpt_dist.sv */
// Shared distance unit: one axis squared per cycle, accumulated over the x, y and z axes.
module nnpt_dist (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  nnpt_pkg::vec_t            a_i,
  input  nnpt_pkg::vec_t            b_i,
  output logic                      done_o,
  output logic [nnpt_pkg::DistW-1:0] dist_o
);
  import nnpt_pkg::*;

  logic [1:0] ax_q, ax_d;
  logic busy_q, busy_d;
  logic [DistW-1:0] acc_q, acc_d;
  logic signed [CoordW:0] da, db, df;
  logic signed [2*CoordW+1:0] dfw;
  logic [2*CoordW+1:0] sq;

  always_comb begin
    unique case (ax_q)
      2'd0: begin
        da = {a_i.x[CoordW-1], a_i.x};
        db = {b_i.x[CoordW-1], b_i.x};
      end
      2'd1: begin
        da = {a_i.y[CoordW-1], a_i.y};
        db = {b_i.y[CoordW-1], b_i.y};
      end
      default: begin
        da = {a_i.z[CoordW-1], a_i.z};
        db = {b_i.z[CoordW-1], b_i.z};
      end
    endcase
    df = da - db;
    dfw = (2*CoordW+2)'(df);
    sq = $unsigned(dfw * dfw);
    busy_d = busy_q;
    ax_d = ax_q;
    acc_d = acc_q;
    if (start_i) begin
      busy_d = 1'b1;
      ax_d = 2'd0;
      acc_d = '0;
    end else if (busy_q) begin
      acc_d = acc_q + DistW'(sq);
      if (ax_q == 2'd2) begin
        busy_d = 1'b0;
      end
      ax_d = ax_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ax_q <= '0;
      done_o <= 1'b0;
    end else begin
      busy_q <= busy_d;
      ax_q <= ax_d;
      done_o <= busy_q && (ax_q == 2'd2);
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign dist_o = acc_q;
endmodule

/* hw/rtl/nearest_neighbor_point_tracker_top.sv */
// Top level of the greedy nearest-neighbor point tracker.
// A point word without frame end is accepted while the tracker collects. A frame end with
// tracking on runs every track against every point through the one shared distance unit,
// one track-point pair at a time; output stalls lengthen it. With tracking off every track
// leaves; with an empty track list every point enters.
// s_axis_tready is low while a frame closes; reset clears the counts and loads defaults.
module nearest_neighbor_point_tracker_top #(
  parameter int unsigned MAX_POINTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: pos_x, pos_y, pos_z, zero padding
  input  logic [63:0] s_axis_tdata,
  // tuser: point_valid
  input  logic        s_axis_tuser,
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: track_id, cur_x, cur_y, cur_z, prev_x, prev_y, prev_z
  output logic [135:0] m_axis_tdata,
  // tuser: event_kind
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import nnpt_pkg::*;
  `include "nearest_neighbor_point_tracker_top_assert.svh"

  localparam int unsigned IW = $clog2(MAX_POINTS);
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);

  typedef enum logic [3:0] {
    ST_COLLECT, ST_TRK, ST_DSTART, ST_DWAIT, ST_DECIDE, ST_EMIT,
    ST_COMPACT, ST_ENTER, ST_CLEANUP
  } state_e;

  state_e state_q;
  logic en_q;
  logic [15:0] maxd_q;
  vec_t pts_q [MAX_POINTS];
  vec_t trk_q [MAX_POINTS];
  logic [IdW-1:0] ids_q [MAX_POINTS];
  logic [MAX_POINTS-1:0] claim_q, keep_q;
  logic [CW-1:0] np_q, tc_q, w_q, pi_q, ncl_q;
  logic [CW-1:0] ncl_next;
  logic [IW-1:0] ti_q;
  logic [IW-1:0] best_i_q;
  logic best_v_q;
  logic [DistW-1:0] best_d_q;
  logic [IdW-1:0] next_id_q;
  logic dist_start, dist_done;
  logic [DistW-1:0] dist_val;
  event_t ev_q;
  logic ov_q;
  logic [31:0] lim;
  logic dec_move;
  logic ev_load;

  assign lim = maxd_q * maxd_q;
  assign cfg_ready_o = 1'b1;
  assign s_axis_tready = (state_q == ST_COLLECT);
  assign dist_start = (state_q == ST_DSTART);
  assign m_axis_tvalid = ov_q;
  assign m_axis_tlast = ev_q.last;
  assign m_axis_tuser = ev_q.kind;
  assign m_axis_tdata = {ev_q.prev.z, ev_q.prev.y, ev_q.prev.x,
                         ev_q.cur.z, ev_q.cur.y, ev_q.cur.x, ev_q.id};

  nnpt_dist u_dist (
    .clk_i, .rst_ni, .start_i(dist_start), .a_i(trk_q[ti_q]),
    .b_i(pts_q[pi_q[IW-1:0]]), .done_o(dist_done), .dist_o(dist_val)
  );

  logic out_free;
  assign out_free = !ov_q || m_axis_tready;

  assign dec_move = best_v_q && !claim_q[best_i_q];
  assign ncl_next = ncl_q + CW'(dec_move);
  assign ev_load = out_free && ((state_q == ST_DECIDE) ||
                   (state_q == ST_EMIT && w_q != tc_q) ||
                   (state_q == ST_ENTER && pi_q != np_q && !claim_q[pi_q[IW-1:0]]));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_COLLECT;
      en_q <= 1'b1;
      maxd_q <= 16'd800;
      np_q <= '0;
      tc_q <= '0;
      claim_q <= '0;
      ov_q <= 1'b0;
      ev_q <= '0;
      w_q <= '0; pi_q <= '0; ti_q <= '0; ncl_q <= '0;
      keep_q <= '0; best_v_q <= 1'b0; best_i_q <= '0; best_d_q <= '0;
      next_id_q <= '0;
    end else begin
      ov_q <= ev_load || (ov_q && !m_axis_tready);
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_TRACK_EN: en_q <= cfg_data_i[0];
          CFG_MAX_DIST: maxd_q <= cfg_data_i;
          default: ;
        endcase
      end
      unique case (state_q)
        ST_COLLECT: if (s_axis_tvalid) begin
          if (s_axis_tuser && np_q < CW'(MAX_POINTS)) begin
            pts_q[np_q[IW-1:0]] <= vec_t'(s_axis_tdata[59:0]);
            np_q <= np_q + 1'b1;
          end
          if (s_axis_tlast) begin
            pi_q <= '0;
            keep_q <= '0;
            ncl_q <= '0;
            if (!en_q) begin
              w_q <= '0; state_q <= ST_EMIT;
            end else if (tc_q == '0) begin
              w_q <= '0; next_id_q <= '0; state_q <= ST_ENTER;
            end else begin
              next_id_q <= ids_q[IW'(tc_q - 1'b1)] + 1'b1;
              ti_q <= IW'(tc_q - 1'b1);
              state_q <= ST_TRK;
            end
          end
        end
        ST_TRK: begin
          pi_q <= '0; best_v_q <= 1'b0;
          state_q <= (np_q == '0) ? ST_DECIDE : ST_DSTART;
        end
        ST_DSTART: state_q <= ST_DWAIT;
        ST_DWAIT: if (dist_done) begin
          if (dist_val < DistW'(lim) && (!best_v_q || dist_val < best_d_q)) begin
            best_v_q <= 1'b1; best_d_q <= dist_val; best_i_q <= pi_q[IW-1:0];
          end
          pi_q <= pi_q + 1'b1;
          state_q <= (pi_q + 1'b1 == np_q) ? ST_DECIDE : ST_DSTART;
        end
        ST_DECIDE: if (out_free) begin
          ev_q.id <= ids_q[ti_q];
          ev_q.last <= (ti_q == '0) && (np_q == ncl_next);
          ncl_q <= ncl_next;
          if (!dec_move) begin
            ev_q.kind <= EV_LEAVE; ev_q.cur <= trk_q[ti_q]; ev_q.prev <= '0;
          end else begin
            claim_q[best_i_q] <= 1'b1; keep_q[ti_q] <= 1'b1;
            ev_q.kind <= EV_MOVE; ev_q.cur <= pts_q[best_i_q];
            ev_q.prev <= trk_q[ti_q];
            trk_q[ti_q] <= pts_q[best_i_q];
          end
          if (ti_q == '0) begin
            pi_q <= '0; w_q <= '0; state_q <= ST_COMPACT;
          end else begin
            ti_q <= ti_q - 1'b1; state_q <= ST_TRK;
          end
        end
        ST_EMIT: begin
          if (w_q == tc_q) begin
            tc_q <= '0;
            state_q <= ST_CLEANUP;
          end else if (out_free) begin
            ev_q.kind <= EV_LEAVE; ev_q.id <= ids_q[w_q[IW-1:0]];
            ev_q.cur <= trk_q[w_q[IW-1:0]]; ev_q.prev <= '0;
            ev_q.last <= (w_q + 1'b1 == tc_q);
            w_q <= w_q + 1'b1;
          end
        end
        ST_COMPACT: begin
          if (pi_q == tc_q) begin
            pi_q <= '0; state_q <= ST_ENTER;
          end else begin
            if (keep_q[pi_q[IW-1:0]]) begin
              trk_q[w_q[IW-1:0]] <= trk_q[pi_q[IW-1:0]];
              ids_q[w_q[IW-1:0]] <= ids_q[pi_q[IW-1:0]];
              w_q <= w_q + 1'b1;
            end
            pi_q <= pi_q + 1'b1;
          end
        end
        ST_ENTER: begin
          if (pi_q == np_q) begin
            tc_q <= w_q;
            state_q <= ST_CLEANUP;
          end else if (claim_q[pi_q[IW-1:0]]) begin
            pi_q <= pi_q + 1'b1;
          end else if (out_free) begin
            ev_q.kind <= EV_ENTER; ev_q.id <= next_id_q;
            ev_q.cur <= pts_q[pi_q[IW-1:0]]; ev_q.prev <= '0;
            ev_q.last <= (ncl_q + 1'b1 == np_q);
            ncl_q <= ncl_q + 1'b1;
            trk_q[w_q[IW-1:0]] <= pts_q[pi_q[IW-1:0]];
            ids_q[w_q[IW-1:0]] <= next_id_q;
            next_id_q <= next_id_q + 1'b1;
            w_q <= w_q + 1'b1;
            pi_q <= pi_q + 1'b1;
          end
        end
        ST_CLEANUP: begin
          np_q <= '0; claim_q <= '0;
          state_q <= ST_COLLECT;
        end
        default: state_q <= ST_COLLECT;
      endcase
    end
  end

  `NNPT_ASSERT_IMP(a_no_in_busy, clk_i, rst_ni, state_q != ST_COLLECT, !s_axis_tready)
  `NNPT_ASSERT_IMP(a_tc_bound, clk_i, rst_ni, 1'b1, tc_q <= CW'(MAX_POINTS))
  `NNPT_ASSERT_NXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
endmodule

/* tb/tb_nearest_neighbor_point_tracker_top.sv */
// Self-checking testbench for the nearest-neighbor point tracker top level.
`timescale 1ns / 1ps

module tb_nearest_neighbor_point_tracker_top;
  import nnpt_pkg::*;

  localparam int unsigned NPTS = 16;
  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int unsigned SETTLE_CYCLES = 1500;

  typedef struct {
    ev_kind_e    kind;
    logic [15:0] id;
    vec_t        cur;
    vec_t        prev;
    bit          last;
  } track_event_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [63:0]  s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [135:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         m_axis_tlast;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic         cfg_index_i = 1'b0;
  logic [15:0]  cfg_data_i = '0;

  nearest_neighbor_point_tracker_top #(.MAX_POINTS(NPTS)) u_dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .s_axis_tlast, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .m_axis_tlast, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  // Tracker state as seen by the predictor.
  bit           track_en = 1'b1;
  logic [15:0]  move_limit = 16'd800;
  vec_t         pend_pts[NPTS];
  int unsigned  pend_cnt = 0;
  vec_t         trk_pos[NPTS];
  logic [15:0]  trk_id[NPTS];
  int unsigned  trk_cnt = 0;

  track_event_t pending_events[$];
  int unsigned  mismatches = 0;
  int unsigned  words_sent = 0;
  int unsigned  frames_closed = 0;
  int unsigned  events_checked = 0;
  longint unsigned cycles = 0;
  bit           steady = 1'b0;
  vec_t         scene[$];

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d events still pending.", cycles,
               pending_events.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic report(input string what);
    mismatches++;
    if (mismatches <= 30) $display("%0t: mismatch: %s", $realtime, what);
  endtask

  function automatic int unsigned draw_gap();
    return steady ? 0 : $urandom_range(15, 0);
  endfunction

  function automatic longint unsigned dist_sq(input vec_t a, input vec_t b);
    longint dx, dy, dz;
    dx = longint'(a.x) - longint'(b.x);
    dy = longint'(a.y) - longint'(b.y);
    dz = longint'(a.z) - longint'(b.z);
    return longint'(dx * dx + dy * dy + dz * dz);
  endfunction

  function automatic void add_event(input ev_kind_e kind, input logic [15:0] id,
                                    input vec_t cur, input vec_t prev);
    track_event_t ev;
    ev.kind = kind;
    ev.id = id;
    ev.cur = cur;
    ev.prev = prev;
    ev.last = 1'b0;
    pending_events.push_back(ev);
  endfunction

  function automatic int nearest_point(input vec_t p);
    longint unsigned lim, best, d;
    int idx;
    lim = longint'(move_limit) * longint'(move_limit);
    best = 0;
    idx = -1;
    for (int i = 0; i < pend_cnt; i++) begin
      d = dist_sq(p, pend_pts[i]);
      if (d < lim && (idx < 0 || d < best)) begin
        best = d;
        idx = i;
      end
    end
    return idx;
  endfunction

  function automatic void predict_frame_end();
    int unsigned start_len, w;
    int c;
    bit claimed[NPTS];
    bit keep[NPTS];
    logic [15:0] next_id;
    start_len = pending_events.size();
    claimed = '{default: 1'b0};
    keep = '{default: 1'b0};
    if (!track_en) begin
      for (int i = 0; i < trk_cnt; i++) add_event(EV_LEAVE, trk_id[i], trk_pos[i], '0);
      trk_cnt = 0;
    end else if (trk_cnt == 0) begin
      for (int i = 0; i < pend_cnt; i++) begin
        trk_pos[i] = pend_pts[i];
        trk_id[i] = 16'(i);
        add_event(EV_ENTER, 16'(i), pend_pts[i], '0);
      end
      trk_cnt = pend_cnt;
    end else begin
      next_id = trk_id[trk_cnt-1] + 16'd1;
      for (int t = trk_cnt - 1; t >= 0; t--) begin
        c = nearest_point(trk_pos[t]);
        if (c < 0 || claimed[c]) begin
          add_event(EV_LEAVE, trk_id[t], trk_pos[t], '0);
        end else begin
          claimed[c] = 1'b1;
          add_event(EV_MOVE, trk_id[t], pend_pts[c], trk_pos[t]);
          trk_pos[t] = pend_pts[c];
          keep[t] = 1'b1;
        end
      end
      w = 0;
      for (int i = 0; i < trk_cnt; i++) begin
        if (keep[i]) begin
          trk_pos[w] = trk_pos[i];
          trk_id[w] = trk_id[i];
          w++;
        end
      end
      for (int i = 0; i < pend_cnt; i++) begin
        if (!claimed[i] && w < NPTS) begin
          trk_pos[w] = pend_pts[i];
          trk_id[w] = next_id;
          add_event(EV_ENTER, next_id, pend_pts[i], '0);
          next_id++;
          w++;
        end
      end
      trk_cnt = w;
    end
    if (pending_events.size() > start_len)
      pending_events[pending_events.size()-1].last = 1'b1;
    pend_cnt = 0;
    frames_closed++;
  endfunction

  // Sends one word on the point stream and updates the prediction on acceptance.
  task automatic send_point(input vec_t p, input bit valid, input bit last);
    int unsigned gap;
    gap = draw_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata <= {4'b0000, p.z, p.y, p.x};
    s_axis_tuser <= valid;
    s_axis_tlast <= last;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    words_sent++;
    if (valid && pend_cnt < NPTS) begin
      pend_pts[pend_cnt] = p;
      pend_cnt++;
    end
    if (last) predict_frame_end();
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] value);
    wait_idle();
    cfg_index_i <= idx;
    cfg_data_i <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_TRACK_EN) track_en = value[0];
    else move_limit = value;
  endtask

  function automatic vec_t mk(input int x, input int y, input int z);
    vec_t v;
    v.x = x[19:0];
    v.y = y[19:0];
    v.z = z[19:0];
    return v;
  endfunction

  function automatic vec_t any_point();
    vec_t v;
    if ($urandom_range(1, 0)) v = mk($urandom(), $urandom(), $urandom());
    else v = mk(int'($urandom_range(4000, 0)) - 2000, int'($urandom_range(4000, 0)) - 2000,
                int'($urandom_range(4000, 0)) - 2000);
    return v;
  endfunction

  // Result checker.
  always @(posedge clk_i) begin
    track_event_t exp_ev;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_events.size() == 0) begin
        report($sformatf("unexpected event word %h", m_axis_tdata));
      end else begin
        exp_ev = pending_events.pop_front();
        events_checked++;
        if (m_axis_tuser != exp_ev.kind)
          report($sformatf("kind %0d, expected %0d", m_axis_tuser, exp_ev.kind));
        if (m_axis_tdata[15:0] != exp_ev.id)
          report($sformatf("id %0d, expected %0d", m_axis_tdata[15:0], exp_ev.id));
        if (m_axis_tdata[75:16] != {exp_ev.cur.z, exp_ev.cur.y, exp_ev.cur.x})
          report($sformatf("cur %h, expected %h", m_axis_tdata[75:16], exp_ev.cur));
        if (m_axis_tdata[135:76] != {exp_ev.prev.z, exp_ev.prev.y, exp_ev.prev.x})
          report($sformatf("prev %h, expected %h", m_axis_tdata[135:76], exp_ev.prev));
        if (m_axis_tlast != exp_ev.last)
          report($sformatf("last %0b, expected %0b", m_axis_tlast, exp_ev.last));
      end
    end
  end

  // Event sink with random stalls.
  initial begin
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  task automatic test_empty_start();
    send_point('0, 1'b0, 1'b1);
  endtask

  task automatic test_extremes_and_overflow();
    send_point(mk(524287, -524288, 524287), 1'b1, 1'b0);
    send_point(mk(-524288, 524287, -524288), 1'b1, 1'b0);
    send_point(mk(0, 0, 0), 1'b1, 1'b1);
    send_point(mk(-1, -1, -1), 1'b0, 1'b1);
    for (int i = 0; i < 17; i++) send_point(mk(i * 1000, i, -i), 1'b1, i == 16);
  endtask

  task automatic test_tie_break();
    send_point(mk(-400, 0, 0), 1'b1, 1'b0);
    send_point(mk(400, 0, 0), 1'b1, 1'b1);
  endtask

  task automatic scene_frames(input int unsigned words);
    int unsigned target;
    int d;
    vec_t p;
    target = words_sent + words;
    while (words_sent < target) begin
      steady = ($urandom_range(5, 0) == 0);
      for (int i = scene.size() - 1; i >= 0; i--) begin
        if ($urandom_range(7, 0) == 0) begin
          scene.delete(i);
        end else begin
          p = scene[i];
          d = int'($urandom_range(600, 0)) - 300; p.x = p.x + d[19:0];
          d = int'($urandom_range(600, 0)) - 300; p.y = p.y + d[19:0];
          d = int'($urandom_range(600, 0)) - 300; p.z = p.z + d[19:0];
          scene[i] = p;
        end
      end
      while (scene.size() < 10 && $urandom_range(2, 0) == 0) scene.push_back(any_point());
      if ($urandom_range(14, 0) == 0) begin
        for (int i = 0; i < 18; i++) send_point(any_point(), 1'b1, i == 17);
      end else if (scene.size() == 0 || $urandom_range(5, 0) == 0) begin
        foreach (scene[i]) begin
          if ($urandom_range(9, 0) == 0) send_point(any_point(), 1'b0, 1'b0);
          send_point(scene[i], 1'b1, 1'b0);
        end
        send_point(any_point(), 1'b0, 1'b1);
      end else begin
        foreach (scene[i]) begin
          if ($urandom_range(9, 0) == 0) send_point(any_point(), 1'b0, 1'b0);
          send_point(scene[i], 1'b1, i == scene.size() - 1);
        end
      end
    end
  endtask

  task automatic test_tracking_motion();
    scene_frames(90);
  endtask

  task automatic test_wide_window();
    write_reg(CFG_MAX_DIST, 16'hFFFF);
    scene_frames(35);
  endtask

  task automatic test_zero_window();
    write_reg(CFG_MAX_DIST, 16'h0000);
    scene_frames(20);
  endtask

  task automatic test_tracking_off();
    write_reg(CFG_TRACK_EN, 16'h0000);
    scene_frames(20);
    write_reg(CFG_TRACK_EN, 16'hFFFF);
  endtask

  task automatic test_random_window();
    for (int k = 0; k < 3; k++) begin
      write_reg(CFG_MAX_DIST, 16'($urandom_range(3000, 200)));
      scene_frames(20);
    end
    write_reg(CFG_MAX_DIST, 16'd800);
    scene_frames(10);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_start();
    test_extremes_and_overflow();
    test_tie_break();
    test_tracking_motion();
    test_wide_window();
    test_zero_window();
    test_tracking_off();
    test_random_window();
    s_axis_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("Sent %0d point words in %0d frames and checked %0d events.", words_sent,
             frames_closed, events_checked);
    $display("Covered windows of 0, 800, 65535 and random sizes, with tracking on and off.");
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches.", mismatches);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* nearest_neighbor_point_tracker_top.f */
+incdir+hw/rtl
hw/rtl/nnpt_pkg.sv
hw/rtl/nnpt_dist.sv
hw/rtl/nearest_neighbor_point_tracker_top.sv
tb/tb_nearest_neighbor_point_tracker_top.sv
